// File: design/velocity_packet_deframer_core_assert.svh
// ----------------------------------------------------------------------------
// Velocity packet deframer assertion macros
// Shorthand for the concurrent checks at the end of the deframer core.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define VELOCITY_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VPD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define VPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/vpd_pkg.sv
// ----------------------------------------------------------------------------
// Velocity packet deframer package
// Frame layout, register indexes, reset values and status codes.
// ----------------------------------------------------------------------------
package vpd_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int SPEED_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int POS_WIDTH       = 3;

   // start, left msb/lsb, right msb/lsb, check, end
   localparam int FRAME_LENGTH    = 7;
   localparam int DATA_BYTES      = 4;

   localparam logic [POS_WIDTH-1:0] POS_IDLE  = '0;
   localparam logic [POS_WIDTH-1:0] POS_DATA0 = POS_WIDTH'(1);
   localparam logic [POS_WIDTH-1:0] POS_DATA3 = POS_WIDTH'(DATA_BYTES);
   localparam logic [POS_WIDTH-1:0] POS_CHECK = POS_WIDTH'(FRAME_LENGTH - 2);
   localparam logic [POS_WIDTH-1:0] POS_END   = POS_WIDTH'(FRAME_LENGTH - 1);

   localparam logic [BYTE_WIDTH-1:0] START_MARKER_RESET = 8'hAA;
   localparam logic [BYTE_WIDTH-1:0] END_MARKER_RESET   = 8'hDD;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_MARKER = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_MARKER   = CSR_INDEX_WIDTH'(1);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_END   = 2'd1,
      ST_BAD_CHECK = 2'd2
   } status_type;

endpackage

// File: design/velocity_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// Velocity packet deframer core
// Hunts for the start marker, collects a 7-byte velocity frame, checks the
// end marker and XOR checksum, and reports one status beat per frame.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake           | content
//   --------+-----+---------------------+----------------------------------
//   req     | in  | req_tvalid/tready   | one received byte
//   rsp     | out | rsp_tvalid/tready   | status + held speeds + checksums
//   csr     | in  | csr_valid/ready     | marker register writes
//
// Cycles: one byte per clock. Each accepted byte updates the position
// counter, XOR and byte store in the cycle it is taken; the seventh byte of
// a frame loads the result register, whose beat shows the cycle after.
// Stalls: req_tready drops only while a finished result sits unaccepted in
// the result register; bytes are taken whenever rsp_tready frees it.
// Reset: synchronous, active high; clears position, XOR, held speeds and
// the result valid, and loads the markers (0xAA / 0xDD). csr is always ready.
//
`include "velocity_packet_deframer_core_assert.svh"

module velocity_packet_deframer_core (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] left_speed, [31:16] right_speed,
                                    // [39:32] computed_check,
                                    // [47:40] received_check
   output logic [1:0]  rsp_tuser,   // [1:0] frame_status

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vpd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [vpd_pkg::BYTE_WIDTH-1:0]      csr_data
);

   // configuration
   logic [vpd_pkg::BYTE_WIDTH-1:0] start_marker_ff, start_marker_in;
   logic [vpd_pkg::BYTE_WIDTH-1:0] end_marker_ff,   end_marker_in;

   // frame state
   logic [vpd_pkg::POS_WIDTH-1:0]   pos_ff,  pos_in;
   logic [vpd_pkg::BYTE_WIDTH-1:0]  xor_ff,  xor_in;
   logic [vpd_pkg::DATA_BYTES*vpd_pkg::BYTE_WIDTH-1:0] data_ff, data_in;
   logic [vpd_pkg::BYTE_WIDTH-1:0]  check_ff, check_in;
   logic signed [vpd_pkg::SPEED_WIDTH-1:0] held_left_ff,  held_left_in;
   logic signed [vpd_pkg::SPEED_WIDTH-1:0] held_right_ff, held_right_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   vpd_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic signed [vpd_pkg::SPEED_WIDTH-1:0] rsp_left_ff,  rsp_left_in;
   logic signed [vpd_pkg::SPEED_WIDTH-1:0] rsp_right_ff, rsp_right_in;
   logic [vpd_pkg::BYTE_WIDTH-1:0] rsp_comp_ff, rsp_comp_in;
   logic [vpd_pkg::BYTE_WIDTH-1:0] rsp_recv_ff, rsp_recv_in;

   logic req_accept;
   logic frame_done;
   logic csr_write;
   vpd_pkg::status_type frame_status;

   // A byte may enter unless a finished result is stuck in the output reg.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   // ---------------------------------------------------------------------
   // Register writes; unknown indexes are dropped.
   // ---------------------------------------------------------------------
   always_comb begin
      start_marker_in = start_marker_ff;
      end_marker_in   = end_marker_ff;
      if (csr_write) begin
         unique case (csr_index)
            vpd_pkg::CSR_START_MARKER: start_marker_in = csr_data;
            vpd_pkg::CSR_END_MARKER:   end_marker_in   = csr_data;
            default: ;
         endcase
      end
   end

   // End-of-frame verdict: a bad end marker beats a checksum mismatch.
   always_comb begin
      if (req_tdata != end_marker_ff) begin
         frame_status = vpd_pkg::ST_BAD_END;
      end else if (xor_ff != check_ff) begin
         frame_status = vpd_pkg::ST_BAD_CHECK;
      end else begin
         frame_status = vpd_pkg::ST_OK;
      end
   end

   assign frame_done = req_accept && (pos_ff == vpd_pkg::POS_END);

   // ---------------------------------------------------------------------
   // Per-byte frame walk
   // ---------------------------------------------------------------------
   always_comb begin
      pos_in        = pos_ff;
      xor_in        = xor_ff;
      data_in       = data_ff;
      check_in      = check_ff;
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      if (req_accept) begin
         unique case (pos_ff) inside
            vpd_pkg::POS_IDLE: begin
               // hunt: everything but the start marker is dropped
               if (req_tdata == start_marker_ff) begin
                  xor_in = '0;
                  pos_in = vpd_pkg::POS_DATA0;
               end
            end
            [vpd_pkg::POS_DATA0:vpd_pkg::POS_DATA3]: begin
               // bytes shift in MSB first: left msb ends up on top
               data_in = {data_ff[(vpd_pkg::DATA_BYTES-1)*vpd_pkg::BYTE_WIDTH-1:0],
                          req_tdata};
               xor_in  = xor_ff ^ req_tdata;
               pos_in  = pos_ff + 1'b1;
            end
            vpd_pkg::POS_CHECK: begin
               check_in = req_tdata;
               pos_in   = pos_ff + 1'b1;
            end
            vpd_pkg::POS_END: begin
               pos_in = vpd_pkg::POS_IDLE;
               if (frame_status == vpd_pkg::ST_OK) begin
                  held_left_in  = data_ff[2*vpd_pkg::SPEED_WIDTH-1:vpd_pkg::SPEED_WIDTH];
                  held_right_in = data_ff[vpd_pkg::SPEED_WIDTH-1:0];
               end
            end
            default: begin
               pos_in = vpd_pkg::POS_IDLE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Result register: loads on the closing byte, holds until taken.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_right_in  = rsp_right_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_recv_in   = rsp_recv_ff;
      if (frame_done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = frame_status;
         rsp_left_in   = held_left_in;
         rsp_right_in  = held_right_in;
         rsp_comp_in   = xor_ff;
         rsp_recv_in   = check_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= vpd_pkg::START_MARKER_RESET;
         end_marker_ff   <= vpd_pkg::END_MARKER_RESET;
         pos_ff          <= vpd_pkg::POS_IDLE;
         xor_ff          <= '0;
         held_left_ff    <= '0;
         held_right_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         start_marker_ff <= start_marker_in;
         end_marker_ff   <= end_marker_in;
         pos_ff          <= pos_in;
         xor_ff          <= xor_in;
         held_left_ff    <= held_left_in;
         held_right_ff   <= held_right_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload: always written before it is read
   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      check_ff      <= check_in;
      rsp_status_ff <= rsp_status_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_right_ff  <= rsp_right_in;
      rsp_comp_ff   <= rsp_comp_in;
      rsp_recv_ff   <= rsp_recv_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_recv_ff, rsp_comp_ff, rsp_right_ff, rsp_left_ff};

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `VPD_ASSERT_NEXT(a_rsp_only_from_end, clock, reset,
      !rsp_valid_ff, !rsp_valid_ff || $past(frame_done),
      "result beat without a closing byte")

   `VPD_ASSERT_IMPLIES(a_no_take_when_full, clock, reset,
      rsp_valid_ff && !rsp_tready, !req_tready,
      "byte taken while result stalled")

   `VPD_ASSERT_IMPLIES(a_pos_in_range, clock, reset,
      1'b1, pos_ff <= vpd_pkg::POS_END,
      "frame position out of range")

   `VPD_ASSERT_IMPLIES(a_ok_means_match, clock, reset,
      rsp_valid_ff && (rsp_status_ff == vpd_pkg::ST_OK), rsp_comp_ff == rsp_recv_ff,
      "ok status with checksum mismatch")

   `VPD_ASSERT_NEXT(a_start_opens_frame, clock, reset,
      req_accept && (pos_ff == vpd_pkg::POS_IDLE) && (req_tdata == start_marker_ff),
      (pos_ff == vpd_pkg::POS_DATA0) && (xor_ff == '0),
      "start marker did not open a frame")

endmodule
